>>> rtl/htw_pkg.sv
package htw_pkg;

  localparam int ID_W        = 4;
  localparam int EXPIRY_W    = 32;
  localparam int RES_W       = 20;
  localparam int DIV_STEPS   = 32;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_DEL   = 2'd1,
    KIND_EXP   = 2'd2,
    KIND_QUIET = 2'd3
  } kind_t;

  // one classified command handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     id;
    logic [EXPIRY_W-1:0] ticks;
  } cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PICK,
    B_APP0,
    B_APP1,
    B_UNL0,
    B_UNL1,
    B_UNL2,
    B_TCHK,
    B_THEAD,
    B_TDEC,
    B_TEXP,
    B_TEND,
    B_RES
  } back_state_t;

endpackage

>>> rtl/htw_ram.sv
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/htw_front.sv
module htw_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [htw_pkg::ID_W-1:0]     timer_id,
  input  logic [htw_pkg::EXPIRY_W-1:0] expiry,
  input  logic [htw_pkg::RES_W-1:0]    tick_resolution,
  output logic                         push_valid,
  output htw_pkg::cmd_t                push_cmd,
  input  logic                         push_full
);

  htw_pkg::front_state_t state, state_next;
  htw_pkg::op_t                 cmd_op;
  logic [htw_pkg::ID_W-1:0]     cmd_id;
  logic [htw_pkg::EXPIRY_W-1:0] num;
  logic [htw_pkg::RES_W-1:0]    divisor;
  logic [htw_pkg::RES_W-1:0]    acc;
  logic [4:0]                   step;
  logic                         in_accept;
  logic [htw_pkg::RES_W:0]      acc_sh;
  logic                         fits;

  assign in_accept = in_valid && !in_stall;
  // restoring division, one quotient bit per cycle shifted into num
  assign acc_sh = {acc, num[htw_pkg::EXPIRY_W-1]};
  assign fits   = acc_sh >= {1'b0, divisor};

  always_comb begin
    state_next = state;
    case (state)
      htw_pkg::F_IDLE: begin
        if (in_accept) begin
          if (htw_pkg::op_t'(op) == htw_pkg::OP_ADD) begin
            state_next = htw_pkg::F_DIV;
          end else if (htw_pkg::op_t'(op) != htw_pkg::OP_NONE) begin
            state_next = htw_pkg::F_PUSH;
          end
        end
      end
      htw_pkg::F_DIV: begin
        if (step == 5'(htw_pkg::DIV_STEPS - 1)) begin
          state_next = htw_pkg::F_PUSH;
        end
      end
      htw_pkg::F_PUSH: begin
        if (!push_full) begin
          state_next = htw_pkg::F_IDLE;
        end
      end
      default: state_next = htw_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = state != htw_pkg::F_IDLE;
    push_valid     = state == htw_pkg::F_PUSH;
    push_cmd.op    = cmd_op;
    push_cmd.id    = cmd_id;
    push_cmd.ticks = (num == '0) ? htw_pkg::EXPIRY_W'(1) : num;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= htw_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_op  <= htw_pkg::op_t'(op);
      cmd_id  <= timer_id;
      num     <= expiry;
      acc     <= '0;
      step    <= '0;
      divisor <= (tick_resolution == '0) ? htw_pkg::RES_W'(1) : tick_resolution;
    end else if (state == htw_pkg::F_DIV) begin
      acc  <= fits ? htw_pkg::RES_W'(acc_sh - {1'b0, divisor})
                   : htw_pkg::RES_W'(acc_sh);
      num  <= {num[htw_pkg::EXPIRY_W-2:0], fits};
      step <= step + 5'd1;
    end
  end

endmodule

>>> rtl/htw_queue.sv
module htw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  htw_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output htw_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int AW = $clog2(htw_pkg::QUEUE_DEPTH);

  htw_pkg::cmd_t entries [htw_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          do_push, do_pop;

  assign full    = count == (AW + 1)'(htw_pkg::QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + AW'(1);
      if (do_pop)  rp <= rp + AW'(1);
      if (do_push && !do_pop) begin
        count <= count + (AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= push_cmd;
    end
  end

endmodule

>>> rtl/htw_back.sv
module htw_back #(
  parameter int SLOT_COUNT = 16,
  parameter int POOL_SIZE  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  htw_pkg::cmd_t            q_cmd,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               kind,
  output logic [htw_pkg::ID_W-1:0] timer_id_res,
  output logic                     error,
  output logic                     last
);

  localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int SW = $clog2(SLOT_COUNT);
  localparam int GW = $clog2(POOL_SIZE + 1);
  localparam int EW = htw_pkg::EXPIRY_W;

  htw_pkg::back_state_t state, state_next;

  htw_pkg::op_t              op_r;
  logic [htw_pkg::ID_W-1:0]  id_r;
  logic                      err_r;
  logic [PW-1:0]             tgt, nx, pv, held;
  logic                      held_v;
  logic [EW-1:0]             rem;
  logic [SW-1:0]             slot_r, cur;
  logic [GW-1:0]             guard;
  logic [POOL_SIZE-1:0]      pending;
  logic [SLOT_COUNT-1:0]     nonempty;

  // memory ports
  logic          head_we, tail_we, next_we, prev_we, rem_we, where_we;
  logic [SW-1:0] head_wa, tail_wa, head_ra, tail_ra;
  logic [PW-1:0] head_wd, tail_wd, head_rd, tail_rd;
  logic [PW-1:0] next_wa, next_wd, prev_wa, prev_wd, next_rd, prev_rd;
  logic [EW-1:0] rem_rd;
  logic [SW-1:0] where_rd;

  logic          can_emit;
  logic          emit;
  logic          q_id_ok;
  logic [PW-1:0] q_tgt;
  logic          app_done_tick;
  logic [SW-1:0] pick_slot;
  logic [EW-1:0] pick_rem;
  logic [SW:0]   pick_sum;

  assign can_emit = !out_valid || !out_stall;
  assign emit     = can_emit && ((state == htw_pkg::B_TEXP && held_v) ||
                                 state == htw_pkg::B_TEND || state == htw_pkg::B_RES);
  assign q_tgt    = PW'(q_cmd.id);
  assign q_id_ok  = 32'(q_cmd.id) < POOL_SIZE;
  assign app_done_tick = op_r == htw_pkg::OP_TICK;

  // slot choice for a (re)filed timer
  always_comb begin
    pick_sum = {1'b0, cur} + (SW + 1)'(rem);
    if (rem >= EW'(SLOT_COUNT)) begin
      pick_slot = (cur == '0) ? SW'(SLOT_COUNT - 1) : cur - SW'(1);
      pick_rem  = rem - EW'(SLOT_COUNT - 1);
    end else begin
      pick_slot = (pick_sum >= (SW + 1)'(SLOT_COUNT))
                  ? SW'(pick_sum - (SW + 1)'(SLOT_COUNT)) : SW'(pick_sum);
      pick_rem  = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      htw_pkg::B_IDLE: begin
        if (!q_empty) begin
          case (q_cmd.op)
            htw_pkg::OP_ADD: begin
              if (q_id_ok && !pending[q_tgt]) state_next = htw_pkg::B_PICK;
              else                            state_next = htw_pkg::B_RES;
            end
            htw_pkg::OP_DEL: begin
              if (q_id_ok && pending[q_tgt]) state_next = htw_pkg::B_UNL0;
              else                           state_next = htw_pkg::B_RES;
            end
            htw_pkg::OP_TICK: state_next = htw_pkg::B_TCHK;
            default:          state_next = htw_pkg::B_IDLE;
          endcase
        end
      end
      htw_pkg::B_PICK: state_next = htw_pkg::B_APP0;
      htw_pkg::B_APP0: begin
        if (nonempty[slot_r])   state_next = htw_pkg::B_APP1;
        else if (app_done_tick) state_next = htw_pkg::B_TCHK;
        else                    state_next = htw_pkg::B_RES;
      end
      htw_pkg::B_APP1: state_next = app_done_tick ? htw_pkg::B_TCHK : htw_pkg::B_RES;
      htw_pkg::B_UNL0: state_next = htw_pkg::B_UNL1;
      htw_pkg::B_UNL1: state_next = htw_pkg::B_UNL2;
      htw_pkg::B_UNL2: state_next = app_done_tick ? htw_pkg::B_TDEC : htw_pkg::B_RES;
      htw_pkg::B_TCHK: begin
        if (guard != GW'(POOL_SIZE) && nonempty[cur]) state_next = htw_pkg::B_THEAD;
        else                                          state_next = htw_pkg::B_TEND;
      end
      htw_pkg::B_THEAD: state_next = htw_pkg::B_UNL0;
      htw_pkg::B_TDEC:  state_next = (rem != '0) ? htw_pkg::B_PICK : htw_pkg::B_TEXP;
      htw_pkg::B_TEXP: begin
        if (!held_v || can_emit) state_next = htw_pkg::B_TCHK;
      end
      htw_pkg::B_TEND: if (can_emit) state_next = htw_pkg::B_IDLE;
      htw_pkg::B_RES:  if (can_emit) state_next = htw_pkg::B_IDLE;
      default:         state_next = htw_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = state == htw_pkg::B_IDLE && !q_empty;
    head_we  = 1'b0;
    tail_we  = 1'b0;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    rem_we   = 1'b0;
    where_we = 1'b0;
    head_wa  = slot_r;
    tail_wa  = slot_r;
    head_wd  = tgt;
    tail_wd  = tgt;
    next_wa  = tail_rd;
    next_wd  = tgt;
    prev_wa  = tgt;
    prev_wd  = tail_rd;
    head_ra  = (state == htw_pkg::B_UNL1) ? where_rd : cur;
    tail_ra  = (state == htw_pkg::B_UNL1) ? where_rd : slot_r;
    case (state)
      htw_pkg::B_APP0: begin
        rem_we   = 1'b1;
        where_we = 1'b1;
        if (!nonempty[slot_r]) begin
          head_we = 1'b1;
          tail_we = 1'b1;
        end
      end
      htw_pkg::B_APP1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        tail_we = 1'b1;
      end
      htw_pkg::B_UNL2: begin
        if (head_rd == tgt && tail_rd == tgt) begin
          // last timer in the slot, list empties
        end else if (head_rd == tgt) begin
          head_we = 1'b1;
          head_wd = nx;
        end else if (tail_rd == tgt) begin
          tail_we = 1'b1;
          tail_wd = pv;
        end else begin
          next_we = 1'b1;
          next_wa = pv;
          next_wd = nx;
          prev_we = 1'b1;
          prev_wa = nx;
          prev_wd = pv;
        end
      end
      default: begin
      end
    endcase
  end

  htw_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_head_mem (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd)
  );
  htw_ram #(.WIDTH(PW), .DEPTH(SLOT_COUNT)) u_tail_mem (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
    .raddr(tail_ra), .rdata(tail_rd)
  );
  htw_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_next_mem (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(tgt), .rdata(next_rd)
  );
  htw_ram #(.WIDTH(PW), .DEPTH(POOL_SIZE)) u_prev_mem (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(tgt), .rdata(prev_rd)
  );
  htw_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_rem_mem (
    .clk(clk), .we(rem_we), .waddr(tgt), .wdata(rem),
    .raddr(tgt), .rdata(rem_rd)
  );
  htw_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_where_mem (
    .clk(clk), .we(where_we), .waddr(tgt), .wdata(slot_r),
    .raddr(tgt), .rdata(where_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= htw_pkg::B_IDLE;
      cur       <= '0;
      pending   <= '0;
      nonempty  <= '0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        htw_pkg::B_IDLE: begin
          if (!q_empty && q_cmd.op == htw_pkg::OP_TICK) begin
            cur    <= (cur == SW'(SLOT_COUNT - 1)) ? '0 : cur + SW'(1);
            held_v <= 1'b0;
          end
        end
        htw_pkg::B_APP0: begin
          pending[tgt]     <= 1'b1;
          nonempty[slot_r] <= 1'b1;
        end
        htw_pkg::B_UNL2: begin
          pending[tgt] <= 1'b0;
          if (head_rd == tgt && tail_rd == tgt) nonempty[slot_r] <= 1'b0;
        end
        htw_pkg::B_TEXP: begin
          if (!held_v || can_emit) held_v <= 1'b1;
        end
        htw_pkg::B_TEND: begin
          if (can_emit) held_v <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      htw_pkg::B_IDLE: begin
        op_r  <= q_cmd.op;
        id_r  <= q_cmd.id;
        tgt   <= q_tgt;
        rem   <= q_cmd.ticks;
        guard <= '0;
        err_r <= q_cmd.op == htw_pkg::OP_ADD && q_id_ok && pending[q_tgt];
      end
      htw_pkg::B_PICK: begin
        slot_r <= pick_slot;
        rem    <= pick_rem;
      end
      htw_pkg::B_UNL1: begin
        nx     <= next_rd;
        pv     <= prev_rd;
        rem    <= rem_rd;
        slot_r <= where_rd;
      end
      htw_pkg::B_TCHK:  guard <= guard + GW'(1);
      htw_pkg::B_THEAD: tgt   <= head_rd;
      htw_pkg::B_TEXP: begin
        if (!held_v || can_emit) begin
          held <= tgt;
          if (held_v) begin
            kind         <= htw_pkg::KIND_EXP;
            timer_id_res <= htw_pkg::ID_W'(held);
            error        <= 1'b0;
            last         <= 1'b0;
          end
        end
      end
      htw_pkg::B_TEND: begin
        if (can_emit) begin
          kind         <= held_v ? htw_pkg::KIND_EXP : htw_pkg::KIND_QUIET;
          timer_id_res <= held_v ? htw_pkg::ID_W'(held) : '0;
          error        <= 1'b0;
          last         <= 1'b1;
        end
      end
      htw_pkg::B_RES: begin
        if (can_emit) begin
          kind         <= (op_r == htw_pkg::OP_ADD) ? htw_pkg::KIND_ADD
                                                    : htw_pkg::KIND_DEL;
          timer_id_res <= id_r;
          error        <= err_r;
          last         <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // no more slots are marked filled than there are pending timers
  a_slots_vs_timers: assert property (@(posedge clk) disable iff (rst)
    $countones(nonempty) <= $countones(pending))
    else $error("more filled slots than pending timers");

  a_held_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == htw_pkg::B_IDLE) |-> !held_v)
    else $error("expired timer left unreported");

  a_quiet_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == htw_pkg::KIND_QUIET) |-> (last && timer_id_res == '0))
    else $error("quiet tick word malformed");

endmodule

>>> rtl/hashed_timer_wheel.sv
// hashed timing wheel over a fixed pool of timers. op 0 adds timer_id with a
// delay of expiry time units (divided by tick_resolution, at least one tick),
// op 1 deletes it, op 2 advances the wheel one slot and reports every timer
// whose count ran out, in list order, one word each with last on the final
// one; a tick with no expiry gives one kind 3 word. op 3 is dropped with no
// word. the front divides expiry by the resolution one quotient bit per
// cycle and passes an add on to the back only once the division is done;
// delete and tick commands skip the division. the back walks the slot
// lists in memories with one write port and one read port. a four-entry
// queue sits between front and back, and the output word register lets
// the back keep working while one word waits. tick_resolution may be
// written only while the block is idle; a value of zero acts as one.
module hashed_timer_wheel #(
  parameter int SLOT_COUNT = 16,
  parameter int POOL_SIZE  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [htw_pkg::RES_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   op,
  input  logic [htw_pkg::ID_W-1:0]     timer_id,
  input  logic [htw_pkg::EXPIRY_W-1:0] expiry,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [htw_pkg::ID_W-1:0]     timer_id_res,
  output logic                         error,
  output logic                         last
);

  logic [htw_pkg::RES_W-1:0] tick_resolution;
  logic                      push_valid, q_full, q_empty, q_pop;
  htw_pkg::cmd_t             push_cmd, q_cmd;

  // resolution register, one time unit per tick out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_resolution <= htw_pkg::RES_W'(1);
    end else if (cfg_write) begin
      tick_resolution <= cfg_data;
    end
  end

  // front: takes words, computes tick counts for adds
  htw_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .timer_id(timer_id), .expiry(expiry),
    .tick_resolution(tick_resolution),
    .push_valid(push_valid), .push_cmd(push_cmd), .push_full(q_full)
  );

  // command queue decoupling the divider from the list walker
  htw_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push_valid), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .pop_cmd(q_cmd), .empty(q_empty)
  );

  // back: slot lists, pending bits, result words
  htw_back #(.SLOT_COUNT(SLOT_COUNT), .POOL_SIZE(POOL_SIZE)) u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .timer_id_res(timer_id_res), .error(error), .last(last)
  );

endmodule
